@@ src/aes_pkg.sv @@
// AES-128 package: transaction types, S-box tables and GF(2^8) helpers.
// Used by every module of the cipher pipeline; no dependencies.
package aes_pkg;

    localparam int unsigned Rounds = 10;

    typedef struct packed {
        logic        kind;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_item_t;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_index_t;

    typedef logic [127:0] state_t;
    typedef logic [127:0] round_key_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n sits at bits 127-8n
    function automatic logic [7:0] get_byte(input state_t s, input int n);
        return s[127 - 8 * n -: 8];
    endfunction

    function automatic state_t sub_shift(input state_t s);
        state_t t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (4 * c + r) -: 8] = sbox(get_byte(s, 4 * ((c + r) % 4) + r));
        return t;
    endfunction

    function automatic state_t inv_shift_sub(input state_t s);
        state_t t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = inv_sbox(get_byte(s, 4 * c + r));
        return t;
    endfunction

    function automatic state_t mix(input state_t s);
        state_t t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            t[127 - 32 * c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32 * c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111 - 32 * c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103 - 32 * c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    // inverse mix = forward mix after the 04/05 pre-step
    function automatic state_t inv_mix(input state_t s);
        state_t t;
        logic [7:0] u, v;
        for (int c = 0; c < 4; c++) begin
            u = xtime(xtime(get_byte(s, 4 * c) ^ get_byte(s, 4 * c + 2)));
            v = xtime(xtime(get_byte(s, 4 * c + 1) ^ get_byte(s, 4 * c + 3)));
            t[127 - 32 * c -: 8] = get_byte(s, 4 * c) ^ u;
            t[119 - 32 * c -: 8] = get_byte(s, 4 * c + 1) ^ v;
            t[111 - 32 * c -: 8] = get_byte(s, 4 * c + 2) ^ u;
            t[103 - 32 * c -: 8] = get_byte(s, 4 * c + 3) ^ v;
        end
        return mix(t);
    endfunction

    function automatic logic [7:0] rcon(input int unsigned i);
        logic [7:0] r;
        r = 8'h01;
        for (int unsigned k = 1; k < 10; k++)
            if (k <= i)
                r = xtime(r);
        return r;
    endfunction

    // round key i+1 from round key i; i counts from 0
    function automatic round_key_t next_key(input round_key_t k, input int unsigned i);
        round_key_t n;
        logic [31:0] t;
        t = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
        t[31:24] = t[31:24] ^ rcon(i);
        n[127:96] = k[127:96] ^ t;
        n[95:64]  = k[95:64] ^ n[127:96];
        n[63:32]  = k[63:32] ^ n[95:64];
        n[31:0]   = k[31:0] ^ n[63:32];
        return n;
    endfunction

endpackage

@@ src/aes_key_sched.sv @@
// AES-128 key schedule: the eleven round keys, registered one stage per round.
// Depends on aes_pkg. Updated only while the block is idle.
module aes_key_sched
    import aes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  round_key_t key,
    output round_key_t round_keys [Rounds + 1]
);

    round_key_t key_reg [Rounds + 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Rounds; i++)
                key_reg[i] <= '0;
        end
        else
        begin
            key_reg[0] <= key;
            for (int i = 1; i <= Rounds; i++)
                key_reg[i] <= next_key(key_reg[i - 1], i - 1);
        end
    end

    assign round_keys = key_reg;

endmodule

@@ src/aes_round_cell.sv @@
// One AES round cell, forward or inverse by the transaction's kind bit.
// Depends on aes_pkg. Registered output, passes the kind and valid along.
module aes_round_cell
    import aes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       last,
    input  logic       in_valid,
    input  logic       in_kind,
    input  state_t     in_state,
    input  round_key_t enc_key,
    input  round_key_t dec_key,
    input  logic       dec_mix,
    output logic       out_valid,
    output logic       out_kind,
    output state_t     out_state
);

    logic   valid_reg;
    logic   kind_reg;
    state_t state_reg;
    state_t state_next;
    state_t enc_t;
    state_t dec_t;

    always_comb
    begin
        enc_t = sub_shift(in_state);
        if (!last)
            enc_t = mix(enc_t);
        dec_t = in_state ^ dec_key;
        if (dec_mix)
            dec_t = inv_mix(dec_t);
        state_next = in_kind ? inv_shift_sub(dec_t) : (enc_t ^ enc_key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= in_kind;
        state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_state = state_reg;

endmodule

@@ src/aes128_block_cipher.sv @@
// AES-128 encrypt/decrypt, one block a cycle while busy is low, through ten unrolled round cells.
// Depends on aes_pkg, aes_key_sched and aes_round_cell.
//
// A block is taken at any edge where start is high and busy is low, so blocks
// may follow back to back. Each block's result is on result with done high
// once it has passed the entry register, the ten round cells and the output
// register. Results are taken in order and cannot be held off. busy is high
// after reset, and in the key write cycle and after it, while the round keys
// settle. cfg_ready is low while any block is in flight.
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    output logic        done,
    output out_item_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam logic [3:0] KeySettle = 4'd10;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    round_key_t  rk [Rounds + 1];

    logic   v   [Rounds + 2];
    logic   k   [Rounds + 2];
    state_t s   [Rounds + 2];
    logic   in_valid_reg;
    logic   in_kind_reg;
    state_t in_state_reg;

    logic [3:0] settle_reg;
    logic [3:0] settle_next;
    logic       cfg_write;
    logic       in_flight;

    always_comb
    begin
        in_flight = in_valid_reg;
        for (int i = 1; i <= Rounds; i++)
            in_flight = in_flight || v[i];
    end

    assign cfg_ready = !in_flight;
    assign cfg_write = cfg_valid && cfg_ready;
    assign busy      = (settle_reg != 4'd0) || cfg_write;

    always_comb
    begin
        if (cfg_write)
            settle_next = KeySettle;
        else if (settle_reg != 4'd0)
            settle_next = settle_reg - 4'd1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= KeySettle;
        else
            settle_reg <= settle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    aes_key_sched u_keys (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        ({key_high_reg, key_low_reg}),
        .round_keys (rk)
    );

    // entry stage: initial whitening with the first key (enc); dec adds the last key in the first round cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_kind_reg  <= item.kind;
        in_state_reg <= {item.block_high, item.block_low};
    end

    assign v[0] = in_valid_reg;
    assign k[0] = in_kind_reg;
    assign s[0] = in_kind_reg ? in_state_reg : (in_state_reg ^ rk[0]);

    for (genvar g = 0; g < Rounds; g++)
    begin : g_round
        aes_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .last      (g == Rounds - 1),
            .in_valid  (v[g]),
            .in_kind   (k[g]),
            .in_state  (s[g]),
            .enc_key   (rk[g + 1]),
            .dec_key   (rk[Rounds - g]),
            .dec_mix   (g != 0),
            .out_valid (v[g + 1]),
            .out_kind  (k[g + 1]),
            .out_state (s[g + 1])
        );
    end

    logic      done_reg;
    out_item_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v[Rounds];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= k[Rounds] ? out_item_t'(s[Rounds] ^ rk[0]) : out_item_t'(s[Rounds]);
    end

    assign v[Rounds + 1] = done_reg;
    assign k[Rounds + 1] = k[Rounds];
    assign s[Rounds + 1] = result_reg;
    assign done          = v[Rounds + 1];
    assign result        = out_item_t'(s[Rounds + 1]);

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        v[Rounds] |=> done) else $error("result strobe lost");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v[Rounds])) else $error("spurious result strobe");
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> v[0]) else $error("transaction not entered");

endmodule
